// ----- sv/fdrq_pkg.sv -----
// Shared types and constants for the frame deferred release queue.
// No dependencies; imported by the queue top level, its checkers and its testbench.
`default_nettype none

package fdrq_pkg;

  // Input action codes.
  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_PRESENT = 2'd1;
  localparam logic [1:0] ACT_FLUSH   = 2'd2;

  // Result status codes.
  localparam logic STAT_RELEASED = 1'b0;
  localparam logic STAT_REJECTED = 1'b1;

  // Configuration register byte addresses.
  localparam logic [2:0] REG_FRAMES_IN_FLIGHT = 3'd0;
  localparam logic [2:0] REG_DEFERRAL_ENABLED = 3'd4;

  // One stored release request.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic [63:0] frame;
  } fdrq_entry_t;

  // One result waiting for delivery.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic        status;
  } fdrq_result_t;

endpackage

`default_nettype wire

// ----- sv/frame_deferred_release_queue.sv -----
// Frame deferred release queue: top level with entry memory and scan sequencer.
// Depends on fdrq_pkg for action codes, status codes and entry types.
//
// Usage:
// The input channel (in_valid/in_stall) carries one action per transaction:
// enqueue a release, mark a frame presented, or flush the queue. The result
// channel (out_valid/out_stall) carries released or rejected entries; out_last
// marks the final result caused by one input transaction. Configuration is
// written over the APB port (frames_in_flight at 0x0, deferral_enabled at 0x4)
// while the block is idle.
// Sequencing: a stored enqueue is written to the entry memory from idle. An
// immediate or rejected enqueue goes on to the closing state to deliver its
// result. A frame-present scan reads entries one by one, refills a released
// slot from the tail and checks it again, and ends in the closing state. A
// flush reads the entries in stored order. The entry memory is touched once
// per cycle. A new transaction is accepted once the previous one is done,
// even while its final result still sits in the output register.
// Reset clears the queue, the frame counter and the output register and sets
// frames_in_flight to 1 and deferral on. A stall on the result channel holds
// the output register and pauses a scan at its next release until it is taken.
`default_nettype none

module frame_deferred_release_queue
  import fdrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // Input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_action,
  input  wire  [2:0]  in_resource_kind,
  input  wire  [31:0] in_resource_id,
  // Result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_released_kind,
  output logic [31:0] out_released_id,
  output logic        out_status,
  output logic        out_last,
  // Configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PCHK  = 3'd1;
  localparam logic [2:0] S_PWR   = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  // Configuration registers.
  logic [3:0] fif_r;
  logic       def_en_r;
  logic       cfg_wr;

  // Sequencer state.
  logic [2:0]   state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [63:0]  fs_r, fs_nxt;
  fdrq_result_t hold_r, hold_nxt;
  logic         hold_v_r, hold_v_nxt;

  // Output register.
  logic         out_valid_r;
  fdrq_result_t out_res_r;
  logic         out_last_r;
  logic         push, push_last, out_free;

  // Entry memory.
  fdrq_entry_t  mem [QUEUE_DEPTH];
  fdrq_entry_t  rd_data_r;
  logic         mem_we, rd_en;
  logic [AW-1:0] waddr, rd_addr;
  fdrq_entry_t  wdata;

  logic          in_acc;
  logic [CW-1:0] idx_plus, tail;
  logic [3:0]    age;
  logic          aged;

  // APB register access.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  always_comb begin
    prdata = 32'd0;
    if (paddr[2]) begin
      prdata = {31'd0, def_en_r};
    end else begin
      prdata = {28'd0, fif_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fif_r    <= 4'd1;
      def_en_r <= 1'b1;
    end else if (cfg_wr) begin
      if ((paddr & 3'b100) == REG_FRAMES_IN_FLIGHT) begin
        fif_r <= pwdata[3:0];
      end else if ((paddr & 3'b100) == REG_DEFERRAL_ENABLED) begin
        def_en_r <= pwdata[0];
      end
    end
  end

  // Handshake and helpers.
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign idx_plus = idx_r + 1'b1;
  assign tail     = cnt_r - 1'b1;
  assign age      = (fif_r == 4'd0) ? 4'd1 : fif_r;
  assign aged     = (rd_data_r.frame + {60'd0, age}) <= fs_r;

  // Sequencer next-state logic.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    fs_nxt     = fs_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    push       = 1'b0;
    push_last  = 1'b0;
    mem_we     = 1'b0;
    waddr      = idx_r[AW-1:0];
    wdata      = rd_data_r;
    rd_en      = 1'b0;
    rd_addr    = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_action)
            ACT_ENQUEUE: begin
              if (!def_en_r || (fif_r == 4'd0)) begin
                hold_nxt   = '{kind: in_resource_kind, id: in_resource_id,
                               status: STAT_RELEASED};
                hold_v_nxt = 1'b1;
                state_nxt  = S_FIN;
              end else if (cnt_r == CW'(QUEUE_DEPTH)) begin
                hold_nxt   = '{kind: in_resource_kind, id: in_resource_id,
                               status: STAT_REJECTED};
                hold_v_nxt = 1'b1;
                state_nxt  = S_FIN;
              end else begin
                mem_we  = 1'b1;
                waddr   = cnt_r[AW-1:0];
                wdata   = '{kind: in_resource_kind, id: in_resource_id, frame: fs_r};
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            ACT_PRESENT: begin
              fs_nxt  = fs_r + 64'd1;
              idx_nxt = '0;
              if (cnt_r != '0) begin
                rd_en     = 1'b1;
                state_nxt = S_PCHK;
              end else begin
                state_nxt = S_FIN;
              end
            end
            ACT_FLUSH: begin
              idx_nxt = '0;
              if (cnt_r != '0) begin
                rd_en     = 1'b1;
                state_nxt = S_FLUSH;
              end else begin
                state_nxt = S_FIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // Entry idx_r is in rd_data_r: release it or step to the next one.
      S_PCHK: begin
        if (aged) begin
          if (!hold_v_r || out_free) begin
            push       = hold_v_r;
            hold_nxt   = '{kind: rd_data_r.kind, id: rd_data_r.id, status: STAT_RELEASED};
            hold_v_nxt = 1'b1;
            cnt_nxt    = tail;
            if (idx_r < tail) begin
              rd_en     = 1'b1;
              rd_addr   = tail[AW-1:0];
              state_nxt = S_PWR;
            end else begin
              state_nxt = S_FIN;
            end
          end
        end else begin
          idx_nxt = idx_plus;
          if (idx_plus < cnt_r) begin
            rd_en   = 1'b1;
            rd_addr = idx_plus[AW-1:0];
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      // The tail entry has arrived: move it into the freed slot and check it.
      S_PWR: begin
        mem_we    = 1'b1;
        state_nxt = S_PCHK;
      end
      // Release entries in stored order, reading one ahead.
      S_FLUSH: begin
        if (!hold_v_r || out_free) begin
          push       = hold_v_r;
          hold_nxt   = '{kind: rd_data_r.kind, id: rd_data_r.id, status: STAT_RELEASED};
          hold_v_nxt = 1'b1;
          idx_nxt    = idx_plus;
          if (idx_plus < cnt_r) begin
            rd_en   = 1'b1;
            rd_addr = idx_plus[AW-1:0];
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_FIN;
          end
        end
      end
      // Deliver the held result as the final one of this transaction.
      S_FIN: begin
        if (hold_v_r) begin
          if (out_free) begin
            push       = 1'b1;
            push_last  = 1'b1;
            hold_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      fs_r        <= 64'd0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      fs_r     <= fs_nxt;
      hold_v_r <= hold_v_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    if (push) begin
      out_res_r  <= hold_r;
      out_last_r <= push_last;
    end
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_released_kind = out_res_r.kind;
  assign out_released_id   = out_res_r.id;
  assign out_status        = out_res_r.status;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// ----- sv/fdrq_checker.sv -----
// Port-level assertions for the frame deferred release queue, bound to its top level.
// Depends on fdrq_pkg for the action and status codes.
`default_nettype none

module fdrq_checker
  import fdrq_pkg::*;
(
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire [1:0]  in_action,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] out_released_id,
  input wire        out_status,
  input wire        out_last
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_released_id))
    else $error("stalled result changed");

  // A rejected enqueue is the only result of its transaction.
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_REJECTED) |-> out_last)
    else $error("rejected result without last");

  // An accepted frame-present transaction always moves the block out of idle.
  a_present_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_PRESENT) |=> in_stall)
    else $error("present transaction did not start a scan");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind frame_deferred_release_queue fdrq_checker u_fdrq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_released_id (out_released_id),
  .out_status      (out_status),
  .out_last        (out_last)
);

`default_nettype wire

// ----- tb/sv/fdrq_release_checker.sv -----
// Checker for the frame deferred release queue: snoops the input, result and
// configuration ports, predicts the released entries and compares them.
// Depends on fdrq_pkg for action codes, status codes and register addresses.

module fdrq_release_checker
  import fdrq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [1:0]  in_action,
  input  wire  [2:0]  in_resource_kind,
  input  wire  [31:0] in_resource_id,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [2:0]  out_released_kind,
  input  wire  [31:0] out_released_id,
  input  wire         out_status,
  input  wire         out_last,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire         pready,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output int          mismatches,
  output int          results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // One release the block owes on its result channel.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] id;
    logic        status;
    logic        last;
  } release_t;

  release_t    owed_q[$];
  int          fail_count = 0;

  // Shadow of the queue contents, frame counter and configuration.
  logic [2:0]  held_kind [QUEUE_DEPTH];
  logic [31:0] held_id   [QUEUE_DEPTH];
  logic [63:0] held_frame[QUEUE_DEPTH];
  int          held;
  logic [63:0] frames_done;
  logic [3:0]  fif;
  logic        defer_on;

  task automatic report_failure(input string what);
    fail_count++;
    $error("%s", what);
  endtask

  function automatic release_t make_release(input logic [2:0] kind, input logic [31:0] id,
                                            input logic status);
    release_t r;
    r.kind   = kind;
    r.id     = id;
    r.status = status;
    r.last   = 1'b0;
    return r;
  endfunction

  // Work out the releases caused by one accepted transaction and queue them.
  task automatic predict_releases(input logic [1:0] act, input logic [2:0] kind,
                                  input logic [31:0] id);
    release_t    batch[$];
    logic [63:0] age;
    logic [63:0] ripe_at;
    int          i;
    int          tail;
    case (act)
      ACT_ENQUEUE: begin
        if (!defer_on || fif == 4'd0) begin
          batch = {batch, make_release(kind, id, STAT_RELEASED)};
        end else if (held >= QUEUE_DEPTH) begin
          batch = {batch, make_release(kind, id, STAT_REJECTED)};
        end else begin
          held_kind[held]  = kind;
          held_id[held]    = id;
          held_frame[held] = frames_done;
          held++;
        end
      end
      ACT_PRESENT: begin
        // A zero ageing is treated as one frame.
        age = (fif == 4'd0) ? 64'd1 : {60'd0, fif};
        frames_done = frames_done + 64'd1;
        i = 0;
        // Swap-and-pop: a released slot takes the tail entry and is looked at again.
        while (i < held) begin
          ripe_at = held_frame[i] + age;
          if (ripe_at <= frames_done) begin
            batch = {batch, make_release(held_kind[i], held_id[i], STAT_RELEASED)};
            tail = held - 1;
            if (i < tail) begin
              held_kind[i]  = held_kind[tail];
              held_id[i]    = held_id[tail];
              held_frame[i] = held_frame[tail];
            end
            held = tail;
          end else begin
            i++;
          end
        end
      end
      ACT_FLUSH: begin
        for (i = 0; i < held; i++) begin
          batch = {batch, make_release(held_kind[i], held_id[i], STAT_RELEASED)};
        end
        held = 0;
      end
      default: begin
      end
    endcase
    if (batch.size() > 0) begin
      batch[batch.size() - 1].last = 1'b1;
    end
    owed_q = {owed_q, batch};
  endtask

  // Per cycle: track register writes, check results, then predict new ones.
  always @(posedge clk) begin
    release_t want;
    if (!rst_n) begin
      held        = 0;
      frames_done = '0;
      fif         = 4'd1;
      defer_on    = 1'b1;
      owed_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_FRAMES_IN_FLIGHT) begin
          fif = pwdata[3:0];
        end else if (paddr == REG_DEFERRAL_ENABLED) begin
          defer_on = pwdata[0];
        end
      end

      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          report_failure($sformatf("unexpected result: kind %0d id 0x%08h status %0d last %0d",
                                   out_released_kind, out_released_id, out_status, out_last));
        end else begin
          want = owed_q.pop_front();
          if (out_released_kind !== want.kind) begin
            report_failure($sformatf("released_kind: expected %0d, got %0d",
                                     want.kind, out_released_kind));
          end
          if (out_released_id !== want.id) begin
            report_failure($sformatf("released_id: expected 0x%08h, got 0x%08h",
                                     want.id, out_released_id));
          end
          if (out_status !== want.status) begin
            report_failure($sformatf("status: expected %0d, got %0d", want.status, out_status));
          end
          if (out_last !== want.last) begin
            report_failure($sformatf("last: expected %0d, got %0d", want.last, out_last));
          end
        end
      end

      if (in_valid && !in_stall) begin
        predict_releases(in_action, in_resource_kind, in_resource_id);
      end
    end
    results_owed <= owed_q.size();
    mismatches   <= fail_count;
  end

endmodule

// ----- tb/sv/frame_deferred_release_queue_tb.sv -----
// Top of the frame deferred release queue testbench: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on fdrq_pkg, the queue RTL
// and fdrq_release_checker.

module frame_deferred_release_queue_tb
  import fdrq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CLK_PERIOD    = 10;
  localparam int         QUEUE_DEPTH   = 32;
  localparam int         SETTLE_CYCLES = 80;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         QUIET_LIMIT   = 3000;
  localparam logic [1:0] ACT_UNUSED    = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [2:0]  in_resource_kind;
  logic [31:0] in_resource_id;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_released_kind;
  logic [31:0] out_released_id;
  logic        out_status;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int results_owed;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_requests  = 0;
  int quiet_cycles   = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  frame_deferred_release_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_resource_kind  (in_resource_kind),
    .in_resource_id    (in_resource_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_released_kind (out_released_kind),
    .out_released_id   (out_released_id),
    .out_status        (out_status),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  fdrq_release_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_resource_kind  (in_resource_kind),
    .in_resource_id    (in_resource_id),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_released_kind (out_released_kind),
    .out_released_id   (out_released_id),
    .out_status        (out_status),
    .out_last          (out_last),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .pready            (pready),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .mismatches        (mismatches),
    .results_owed      (results_owed)
  );

  // Offer one transaction after an optional random gap; return once accepted.
  task automatic send_item(input logic [1:0] act, input logic [2:0] kind,
                           input logic [31:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_resource_kind <= kind;
    in_resource_id   <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly enqueues and frame presents, with some flushes and unused actions.
  task automatic random_item();
    int         pick;
    logic [1:0] act;
    logic [2:0] kind;
    pick = $urandom_range(99);
    if (pick < 52) act = ACT_ENQUEUE;
    else if (pick < 86) act = ACT_PRESENT;
    else if (pick < 95) act = ACT_FLUSH;
    else act = ACT_UNUSED;
    kind = ($urandom_range(9) == 0) ? 3'd7 : 3'($urandom_range(6));
    send_item(act, kind, $urandom());
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every owed result, then let a silent scan finish.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] frames, input logic defer);
    wait_until_drained();
    write_reg(REG_FRAMES_IN_FLIGHT, {28'd0, frames});
    write_reg(REG_DEFERRAL_ENABLED, {31'd0, defer});
  endtask

  task automatic run_phase(input logic [3:0] frames, input logic defer, input int send_pct,
                           input int recv_pct, input int items);
    configure(frames, defer);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (items) random_item();
  endtask

  // Receiver: random stalls, or one long hold-off per request.
  initial begin : receiver
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_action        <= ACT_ENQUEUE;
    in_resource_kind <= 3'd0;
    in_resource_id   <= 32'd0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= REG_FRAMES_IN_FLIGHT;
    pwdata           <= 32'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: field extremes, swap-and-pop scan, empty scan and flush.
    send_idle_pct = 24;
    recv_idle_pct = 53;
    write_reg(REG_FRAMES_IN_FLIGHT, 32'd1);
    write_reg(REG_DEFERRAL_ENABLED, 32'd1);
    send_item(ACT_ENQUEUE, 3'd0, 32'h0000_0000);
    send_item(ACT_ENQUEUE, 3'd7, 32'hFFFF_FFFF);
    send_item(ACT_ENQUEUE, 3'd6, 32'hA5A5_5A5A);
    send_item(ACT_ENQUEUE, 3'd1, 32'h5A5A_A5A5);
    send_item(ACT_UNUSED, 3'd3, 32'h1234_5678);
    send_item(ACT_PRESENT, 3'd0, 32'd0);
    send_item(ACT_PRESENT, 3'd0, 32'd0);
    send_item(ACT_FLUSH, 3'd0, 32'd0);
    send_item(ACT_ENQUEUE, 3'd2, 32'h0000_0001);
    send_item(ACT_ENQUEUE, 3'd3, 32'h8000_0000);
    send_item(ACT_ENQUEUE, 3'd4, 32'h7FFF_FFFF);
    send_item(ACT_FLUSH, 3'd0, 32'd0);

    // Entries queued with three frames of ageing, then released with zero ageing.
    configure(4'd3, 1'b1);
    send_item(ACT_ENQUEUE, 3'd5, 32'hDEAD_0001);
    send_item(ACT_ENQUEUE, 3'd2, 32'hDEAD_0002);
    send_item(ACT_PRESENT, 3'd0, 32'd0);
    configure(4'd0, 1'b1);
    send_item(ACT_ENQUEUE, 3'd6, 32'h0F0F_F0F0);
    send_item(ACT_PRESENT, 3'd0, 32'd0);

    // Deferral off releases at once.
    configure(4'd8, 1'b0);
    send_item(ACT_ENQUEUE, 3'd5, 32'hCAFE_0005);
    send_item(ACT_ENQUEUE, 3'd7, 32'h0000_FFFF);

    // Random part, sender idling more rarely than the receiver.
    run_phase(4'd1, 1'b1, 24, 53, 25);
    run_phase(4'd8, 1'b1, 24, 53, 12);
    // Overfill the queue so that enqueues are rejected.
    repeat (36) send_item(ACT_ENQUEUE, 3'($urandom_range(7)), $urandom());
    repeat (8) random_item();
    run_phase(4'd15, 1'b1, 24, 53, 20);

    // Sender idling more than the receiver, with one long hold-off.
    configure(4'd2, 1'b1);
    send_idle_pct = 53;
    recv_idle_pct = 24;
    hold_requests++;
    repeat (10) send_item(ACT_ENQUEUE, 3'($urandom_range(7)), $urandom());
    repeat (4) send_item(ACT_PRESENT, 3'($urandom_range(7)), $urandom());
    repeat (10) random_item();
    run_phase(4'd0, 1'b1, 53, 24, 15);
    run_phase(4'd5, 1'b0, 53, 24, 15);

    // No idling on either side.
    run_phase(4'd4, 1'b1, 0, 0, 25);

    wait_until_drained();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
